[design/nps_pkg.sv]
// shared types and constants of the priority scheduler
package nps_pkg;

    localparam int JOB_LIMIT = 16;
    localparam int DATA_W    = 16;
    localparam int IDX_W     = 4;
    localparam int CLK_W     = 21;
    localparam int SUM_W     = 25;

    typedef logic        [DATA_W-1:0] t_data;
    typedef logic signed [DATA_W-1:0] t_pri;
    typedef logic        [IDX_W-1:0]  t_idx;
    typedef logic        [CLK_W-1:0]  t_clk;
    typedef logic        [SUM_W-1:0]  t_sum;

    // item handed from the front to the back
    typedef struct packed {
        t_data arrival;
        t_data burst;
        t_pri  priority_req;
        logic  last;
        logic  keep;
    } t_job;

    // one scheduled job
    typedef struct packed {
        t_idx  job_index;
        t_data job_arrival;
        t_data job_burst;
        t_pri  job_priority;
        t_clk  finish_time;
        t_clk  wait_span;
        t_clk  turn_span;
        t_sum  total_waiting;
        t_sum  total_turnaround;
        logic  final_res;
    } t_res;

endpackage

[design/nps_fifo.sv]
// small first-word-fall-through queue
module nps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = AW + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[design/nps_front.sv]
// front end: takes jobs in, drops those past table capacity, tags set ends
module nps_front #(
    parameter int CAP = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  nps_pkg::t_data     i_arrival_time,
    input  nps_pkg::t_data     i_burst_time,
    input  nps_pkg::t_pri      i_priority_req,
    input  logic               i_last,
    output logic               o_q_push,
    output nps_pkg::t_job      o_q_job,
    input  logic               i_q_full
);

    localparam int CW = $clog2(CAP + 1);

    logic [CW-1:0] r_cnt;
    logic          accept;
    logic          keep;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;
    assign keep   = (r_cnt < CW'(CAP));

    // a dropped item still has to pass when it closes the set
    assign o_q_push = accept && (keep || i_last);

    always_comb begin
        o_q_job.arrival      = i_arrival_time;
        o_q_job.burst        = i_burst_time;
        o_q_job.priority_req = i_priority_req;
        o_q_job.last         = i_last;
        o_q_job.keep         = keep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_cnt <= '0;
            end else if (keep) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

endmodule

[design/nps_back.sv]
// back end: job table and the scan sequencer that picks and times each job
module nps_back #(
    parameter int CAP = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  nps_pkg::t_job  i_q_job,
    output logic           o_q_pop,
    input  logic           i_r_full,
    output logic           o_r_push,
    output nps_pkg::t_res  o_r_res
);

    localparam int IW = $clog2(CAP);
    localparam int CW = $clog2(CAP + 1);

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_SCAN = 6'b000010,
        S_ADV  = 6'b000100,
        S_TURN = 6'b001000,
        S_WAIT = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    nps_pkg::t_data r_arr [CAP];
    nps_pkg::t_data r_bur [CAP];
    nps_pkg::t_pri  r_pri [CAP];
    logic [CAP-1:0] r_done;

    logic [CW-1:0]  r_n;
    logic [CW-1:0]  r_k;
    logic [IW-1:0]  r_idx;
    nps_pkg::t_clk  r_clock;
    nps_pkg::t_sum  r_wsum;
    nps_pkg::t_sum  r_tsum;

    // best arrived job so far
    logic           r_a_valid;
    logic [IW-1:0]  r_a_idx;
    nps_pkg::t_data r_a_arr;
    nps_pkg::t_data r_a_bur;
    nps_pkg::t_pri  r_a_pri;
    // earliest unfinished job, for an idle clock
    logic           r_b_valid;
    logic [IW-1:0]  r_b_idx;
    nps_pkg::t_data r_b_arr;
    nps_pkg::t_data r_b_bur;
    nps_pkg::t_pri  r_b_pri;

    logic [IW-1:0]  r_p_idx;
    nps_pkg::t_data r_p_arr;
    nps_pkg::t_data r_p_bur;
    nps_pkg::t_pri  r_p_pri;
    nps_pkg::t_clk  r_turn;
    nps_pkg::t_clk  r_wait;

    nps_pkg::t_data e_arr;
    nps_pkg::t_data e_bur;
    nps_pkg::t_pri  e_pri;
    logic           e_done;
    logic           e_arrived;
    logic           a_take;
    logic           b_take;
    logic           scan_end;
    logic           set_end;
    logic           load_go;
    nps_pkg::t_sum  n_wsum;
    nps_pkg::t_sum  n_tsum;
    nps_pkg::t_clk  adv_base;

    assign e_arr     = r_arr[r_idx];
    assign e_bur     = r_bur[r_idx];
    assign e_pri     = r_pri[r_idx];
    assign e_done    = r_done[r_idx];
    assign e_arrived = (nps_pkg::t_clk'(e_arr) <= r_clock);

    // later load order never wins a full tie, so compares are strict
    assign a_take = !e_done && e_arrived &&
                    (!r_a_valid || (e_pri > r_a_pri) ||
                     ((e_pri == r_a_pri) && (e_arr < r_a_arr)));
    assign b_take = !e_done &&
                    (!r_b_valid || (e_arr < r_b_arr) ||
                     ((e_arr == r_b_arr) && (e_pri > r_b_pri)));

    assign scan_end = ((CW'(r_idx) + CW'(1)) == r_n);
    assign set_end  = ((r_k + CW'(1)) == r_n);
    assign load_go  = (r_state == S_LOAD) && !i_q_empty;
    assign o_q_pop  = load_go;
    assign o_r_push = (r_state == S_EMIT) && !i_r_full;
    assign n_wsum   = r_wsum + nps_pkg::t_sum'(r_wait);
    assign n_tsum   = r_tsum + nps_pkg::t_sum'(r_turn);
    assign adv_base = r_a_valid ? r_clock : nps_pkg::t_clk'(r_b_arr);

    always_comb begin
        o_r_res.job_index        = nps_pkg::t_idx'(r_p_idx);
        o_r_res.job_arrival      = r_p_arr;
        o_r_res.job_burst        = r_p_bur;
        o_r_res.job_priority     = r_p_pri;
        o_r_res.finish_time      = r_clock;
        o_r_res.wait_span        = r_wait;
        o_r_res.turn_span        = r_turn;
        o_r_res.total_waiting    = n_wsum;
        o_r_res.total_turnaround = n_tsum;
        o_r_res.final_res        = set_end;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (load_go && i_q_job.last) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_ADV;
                end
            end
            S_ADV:  n_state = S_TURN;
            S_TURN: n_state = S_WAIT;
            S_WAIT: n_state = S_EMIT;
            S_EMIT: begin
                if (o_r_push) begin
                    n_state = set_end ? S_LOAD : S_SCAN;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_done    <= '0;
            r_n       <= '0;
            r_k       <= '0;
            r_idx     <= '0;
            r_clock   <= '0;
            r_wsum    <= '0;
            r_tsum    <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_LOAD: begin
                    if (load_go) begin
                        if (i_q_job.keep) begin
                            r_n <= r_n + CW'(1);
                        end
                        r_idx     <= '0;
                        r_k       <= '0;
                        r_a_valid <= 1'b0;
                        r_b_valid <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (a_take) begin
                        r_a_valid <= 1'b1;
                    end
                    if (b_take) begin
                        r_b_valid <= 1'b1;
                    end
                    r_idx <= r_idx + IW'(1);
                end
                S_ADV: begin
                    r_clock <= adv_base + nps_pkg::t_clk'(r_a_valid ? r_a_bur : r_b_bur);
                end
                S_EMIT: begin
                    if (o_r_push) begin
                        r_idx     <= '0;
                        r_a_valid <= 1'b0;
                        r_b_valid <= 1'b0;
                        if (set_end) begin
                            r_done  <= '0;
                            r_n     <= '0;
                            r_k     <= '0;
                            r_clock <= '0;
                            r_wsum  <= '0;
                            r_tsum  <= '0;
                        end else begin
                            r_done[r_p_idx] <= 1'b1;
                            r_k    <= r_k + CW'(1);
                            r_wsum <= n_wsum;
                            r_tsum <= n_tsum;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_go && i_q_job.keep) begin
            r_arr[r_n[IW-1:0]] <= i_q_job.arrival;
            r_bur[r_n[IW-1:0]] <= i_q_job.burst;
            r_pri[r_n[IW-1:0]] <= i_q_job.priority_req;
        end
        if (r_state == S_SCAN) begin
            if (a_take) begin
                r_a_idx <= r_idx;
                r_a_arr <= e_arr;
                r_a_bur <= e_bur;
                r_a_pri <= e_pri;
            end
            if (b_take) begin
                r_b_idx <= r_idx;
                r_b_arr <= e_arr;
                r_b_bur <= e_bur;
                r_b_pri <= e_pri;
            end
        end
        if (r_state == S_ADV) begin
            r_p_idx <= r_a_valid ? r_a_idx : r_b_idx;
            r_p_arr <= r_a_valid ? r_a_arr : r_b_arr;
            r_p_bur <= r_a_valid ? r_a_bur : r_b_bur;
            r_p_pri <= r_a_valid ? r_a_pri : r_b_pri;
        end
        if (r_state == S_TURN) begin
            r_turn <= r_clock - nps_pkg::t_clk'(r_p_arr);
        end
        if (r_state == S_WAIT) begin
            r_wait <= r_turn - nps_pkg::t_clk'(r_p_bur);
        end
    end

endmodule

[design/nonpreemptive_priority_scheduler.sv]
// top level of the non-preemptive priority scheduler
//
//  channel  | direction | transfer when    | payload
//  ---------+-----------+------------------+------------------------------------------
//  jobs     | in        | i_push & !o_full | arrival, burst, priority, last
//  results  | out       | i_pop & !o_empty | index, job fields, times, running totals
//
// jobs load through a 4-deep job queue into the back end table, one per cycle while
// the back end is in S_LOAD; for a set of n jobs each result takes a scan of all n
// table entries, then the states S_ADV, S_TURN, S_WAIT and S_EMIT
// while the back end schedules, the job queue keeps taking items until it fills
// a full 2-entry result queue stalls the back end only; reset is synchronous
// and clears all control state
module nonpreemptive_priority_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [15:0]           i_arrival_time,
    input  logic [15:0]           i_burst_time,
    input  logic signed [15:0]    i_priority_req,
    input  logic                  i_last,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [3:0]            o_job_index,
    output logic [15:0]           o_job_arrival,
    output logic [15:0]           o_job_burst,
    output logic signed [15:0]    o_job_priority,
    output logic [20:0]           o_finish_time,
    output logic [20:0]           o_wait_span,
    output logic [20:0]           o_turn_span,
    output logic [24:0]           o_total_waiting,
    output logic [24:0]           o_total_turnaround,
    output logic                  o_final_res
);

    localparam int CAP      = (MAX_PROCS < nps_pkg::JOB_LIMIT) ? MAX_PROCS
                                                               : nps_pkg::JOB_LIMIT;
    localparam int JQ_DEPTH = 4;
    localparam int RQ_DEPTH = 2;
    localparam int JOB_W    = $bits(nps_pkg::t_job);
    localparam int RES_W    = $bits(nps_pkg::t_res);

    logic              jq_push;
    logic              jq_full;
    logic              jq_pop;
    logic              jq_empty;
    nps_pkg::t_job     jq_in;
    logic [JOB_W-1:0]  jq_out;
    logic              rq_push;
    logic              rq_full;
    nps_pkg::t_res     rq_in;
    logic [RES_W-1:0]  rq_out;
    nps_pkg::t_res     res;

    nps_front #(
        .CAP (CAP)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_arrival_time (i_arrival_time),
        .i_burst_time   (i_burst_time),
        .i_priority_req (i_priority_req),
        .i_last         (i_last),
        .o_q_push       (jq_push),
        .o_q_job        (jq_in),
        .i_q_full       (jq_full)
    );

    nps_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JQ_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (jq_push),
        .i_data  (jq_in),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_data  (jq_out),
        .o_empty (jq_empty)
    );

    nps_back #(
        .CAP (CAP)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (jq_empty),
        .i_q_job   (nps_pkg::t_job'(jq_out)),
        .o_q_pop   (jq_pop),
        .i_r_full  (rq_full),
        .o_r_push  (rq_push),
        .o_r_res   (rq_in)
    );

    nps_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RQ_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_in),
        .o_full  (rq_full),
        .i_pop   (i_pop),
        .o_data  (rq_out),
        .o_empty (o_empty)
    );

    assign res                = nps_pkg::t_res'(rq_out);
    assign o_job_index        = res.job_index;
    assign o_job_arrival      = res.job_arrival;
    assign o_job_burst        = res.job_burst;
    assign o_job_priority     = res.job_priority;
    assign o_finish_time      = res.finish_time;
    assign o_wait_span        = res.wait_span;
    assign o_turn_span        = res.turn_span;
    assign o_total_waiting    = res.total_waiting;
    assign o_total_turnaround = res.total_turnaround;
    assign o_final_res        = res.final_res;

endmodule

[design/nps_checker.sv]
// port-level checks of the scheduler, bound to the top level
module nps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_pop,
    input logic               o_empty,
    input logic [3:0]         o_job_index,
    input logic [15:0]        o_job_arrival,
    input logic [15:0]        o_job_burst,
    input logic [20:0]        o_finish_time,
    input logic [20:0]        o_wait_span,
    input logic [20:0]        o_turn_span,
    input logic [24:0]        o_total_turnaround
);

    // nothing to transfer right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_job_index) &&
                                  $stable(o_finish_time)))
        else $error("stalled result changed");

    a_wait_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (21'(o_wait_span + 21'(o_job_burst)) == o_turn_span))
        else $error("waiting plus burst differs from turnaround");

    a_turn_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (21'(o_turn_span + 21'(o_job_arrival)) == o_finish_time))
        else $error("turnaround plus arrival differs from completion");

    // running total includes the current job
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_total_turnaround >= 25'(o_turn_span)))
        else $error("turnaround total below job turnaround");

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_pop              (i_pop),
    .o_empty            (o_empty),
    .o_job_index        (o_job_index),
    .o_job_arrival      (o_job_arrival),
    .o_job_burst        (o_job_burst),
    .o_finish_time      (o_finish_time),
    .o_wait_span        (o_wait_span),
    .o_turn_span        (o_turn_span),
    .o_total_turnaround (o_total_turnaround)
);
